@@ sv/mrlt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlt_pkg
// Shared types and constants of the memory region lease table.
// ----------------------------------------------------------------------------
package mrlt_pkg;

   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum logic [2:0] {
      OP_ADD     = 3'd0,
      OP_REMOVE  = 3'd1,
      OP_ACQ_LOC = 3'd2,
      OP_ACQ_REM = 3'd3,
      OP_RELEASE = 3'd4,
      OP_CLOSE   = 3'd5,
      OP_REOPEN  = 3'd6,
      OP_TRACKS  = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      ST_OK          = 4'd0,
      ST_BAD_RANGE   = 4'd1,
      ST_BAD_PERM    = 4'd2,
      ST_SHUTDOWN    = 4'd3,
      ST_OVERLAP     = 4'd4,
      ST_IDS_GONE    = 4'd5,
      ST_TABLE_FULL  = 4'd6,
      ST_NOT_REG     = 4'd7,
      ST_RANGE_REJ   = 4'd8,
      ST_STALE_ID    = 4'd9,
      ST_PERM_DENIED = 4'd10,
      ST_REOPEN_REF  = 4'd11,
      ST_LEASE_LIMIT = 4'd12
   } status_type;

   localparam logic [1:0] RIGHTS_LOCAL_RW  = 2'd0;
   localparam logic [1:0] RIGHTS_GLOBAL_RW = 2'd2;
   localparam logic [1:0] RIGHTS_INVALID   = 2'd3;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_CHECK    = 6'b000010,
      S_SCAN     = 6'b000100,
      S_SCAN_END = 6'b001000,
      S_READ     = 6'b010000,
      S_EXEC     = 6'b100000
   } state_type;

   typedef struct packed {
      logic load_req;
      logic check;
      logic scan_issue;
      logic rel_read;
      logic exec;
   } cmd_type;

   typedef struct packed {
      logic   early_fail;
      op_type op;
      logic   scan_last;
   } sts_type;

endpackage

@@ sv/mrlt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlt_ctrl
// Sequencer: accept a transaction, run checks, scan or read the slot memory
// where needed, execute and hand the result to the output register.
// ----------------------------------------------------------------------------
module mrlt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  mrlt_pkg::sts_type sts,
   output mrlt_pkg::cmd_type cmd
);
   import mrlt_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.load_req   = req_tvalid && (state_ff == S_IDLE);
      cmd.check      = (state_ff == S_CHECK);
      cmd.scan_issue = (state_ff == S_SCAN);
      cmd.rel_read   = (state_ff == S_READ);
      cmd.exec       = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.early_fail) begin
               state_in = S_EXEC;
            end else begin
               case (sts.op)
                  OP_ADD, OP_REMOVE, OP_ACQ_LOC, OP_ACQ_REM, OP_TRACKS: state_in = S_SCAN;
                  OP_RELEASE: state_in = S_READ;
                  default:    state_in = S_EXEC;
               endcase
            end
         end
         S_SCAN: begin
            if (sts.scan_last) state_in = S_SCAN_END;
         end
         S_SCAN_END: state_in = S_EXEC;
         S_READ:     state_in = S_EXEC;
         S_EXEC: begin
            if (cmd.exec) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ sv/mrlt_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlt_dp
// Datapath: request registers, slot memory, scan accumulators, id sequence
// and result registers.
// ----------------------------------------------------------------------------
module mrlt_dp #(
   parameter int NUM_SLOTS  = 16,
   parameter int LEASE_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  mrlt_pkg::cmd_type cmd,
   output mrlt_pkg::sts_type sts,
   input  logic [2:0]        req_op,
   input  logic [63:0]       req_base,
   input  logic [63:0]       req_length,
   input  logic [1:0]        req_rights,
   input  logic [63:0]       req_expected_id,
   input  logic              req_is_write,
   input  logic [3:0]        req_release_slot,
   input  logic              csr_we,
   input  logic [63:0]       csr_wdata,
   output logic [3:0]        rsp_status,
   output logic [63:0]       rsp_new_id,
   output logic [3:0]        rsp_lease_slot,
   output logic [63:0]       rsp_lease_base,
   output logic [63:0]       rsp_lease_length,
   output logic              rsp_flag
);
   import mrlt_pkg::*;

   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [LEASE_BITS-1:0] LEASE_MAX = {LEASE_BITS{1'b1}};

   // request
   op_type         op_ff;
   logic [63:0]    base_ff, len_ff, exp_id_ff;
   logic [1:0]     rights_ff;
   logic           wr_ff;
   logic [3:0]     rel_ff;

   // table state
   logic [NUM_SLOTS-1:0] used_ff, used_in, hidden_ff, hidden_in;
   logic                 closing_ff, closing_in;
   logic [63:0]          seq_ff, seq_in, ns_ff;

   logic [63:0]           mem_base   [NUM_SLOTS];
   logic [63:0]           mem_len    [NUM_SLOTS];
   logic [1:0]            mem_rights [NUM_SLOTS];
   logic [63:0]           mem_id     [NUM_SLOTS];
   logic [LEASE_BITS-1:0] mem_cnt    [NUM_SLOTS];

   // read port
   logic [SW-1:0]         rd_addr;
   logic [SW-1:0]         rd_idx_ff;
   logic                  rd_valid_ff;
   logic [63:0]           rd_base_ff, rd_len_ff, rd_id_ff;
   logic [1:0]            rd_rights_ff;
   logic [LEASE_BITS-1:0] rd_cnt_ff;

   // scan
   logic [SW-1:0]         scan_idx_ff;
   logic                  overlap_ff, free_found_ff, hit_found_ff;
   logic [SW-1:0]         free_slot_ff, hit_idx_ff;
   logic [63:0]           hit_base_ff, hit_len_ff, hit_id_ff;
   logic [1:0]            hit_rights_ff;
   logic [LEASE_BITS-1:0] hit_cnt_ff;
   status_type            early_ff, early;

   logic [63:0] req_end, rd_end, hit_end;
   logic        range_ok, rd_vis, hit_take, ovl_take;
   logic [SW-1:0] rel_idx;

   // write port
   logic                  row_we, cnt_we;
   logic [SW-1:0]         row_addr, cnt_addr;
   logic [63:0]           row_id;
   logic [LEASE_BITS-1:0] cnt_data;

   status_type  st_out;
   logic [63:0] nid_out, lbase_out, llen_out;
   logic [3:0]  lslot_out;
   logic        flag_out;
   logic [63:0] nid0, nid1, seq1, seq2;

   assign req_end  = base_ff + len_ff;
   assign rd_end   = rd_base_ff + rd_len_ff;
   assign hit_end  = hit_base_ff + hit_len_ff;
   assign range_ok = (len_ff != 64'd0) && (base_ff <= ~len_ff);
   assign rel_idx  = SW'(rel_ff);
   assign rd_addr  = cmd.rel_read ? rel_idx : scan_idx_ff;
   assign rd_vis   = used_ff[rd_idx_ff] && !hidden_ff[rd_idx_ff];

   always_comb begin
      early = ST_OK;
      case (op_ff)
         OP_ADD: begin
            if (!range_ok) early = ST_BAD_RANGE;
            else if (rights_ff == RIGHTS_INVALID) early = ST_BAD_PERM;
            else if (closing_ff) early = ST_SHUTDOWN;
         end
         OP_ACQ_LOC, OP_ACQ_REM: begin
            if (!range_ok) early = ST_RANGE_REJ;
            else if (closing_ff) early = ST_SHUTDOWN;
         end
         OP_RELEASE: begin
            if (32'(rel_ff) >= NUM_SLOTS || !used_ff[rel_idx]) early = ST_LEASE_LIMIT;
         end
         OP_REOPEN: begin
            if (|(used_ff & ~hidden_ff)) early = ST_REOPEN_REF;
         end
         default: early = ST_OK;
      endcase
   end

   always_comb begin
      sts            = '0;
      sts.early_fail = (early != ST_OK);
      sts.op         = op_ff;
      sts.scan_last  = (scan_idx_ff == SW'(NUM_SLOTS - 1));
   end

   always_comb begin
      ovl_take = rd_vis && (base_ff < rd_end) && (rd_base_ff < req_end);
      case (op_ff)
         OP_ACQ_LOC, OP_ACQ_REM:
            hit_take = rd_vis && (rd_base_ff <= base_ff) &&
                       (!hit_found_ff || rd_base_ff > hit_base_ff);
         default:
            hit_take = rd_vis && !hit_found_ff && (rd_base_ff == base_ff) &&
                       (rd_len_ff == len_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff     <= op_type'(req_op);
         base_ff   <= req_base;
         len_ff    <= req_length;
         rights_ff <= req_rights;
         exp_id_ff <= req_expected_id;
         wr_ff     <= req_is_write;
         rel_ff    <= req_release_slot;
      end
      if (cmd.check) early_ff <= early;
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_issue || cmd.rel_read) begin
         rd_base_ff   <= mem_base[rd_addr];
         rd_len_ff    <= mem_len[rd_addr];
         rd_rights_ff <= mem_rights[rd_addr];
         rd_id_ff     <= mem_id[rd_addr];
         rd_cnt_ff    <= mem_cnt[rd_addr];
         rd_idx_ff    <= rd_addr;
      end
      if (row_we) begin
         mem_base[row_addr]   <= base_ff;
         mem_len[row_addr]    <= len_ff;
         mem_rights[row_addr] <= rights_ff;
         mem_id[row_addr]     <= row_id;
      end
      if (cnt_we) mem_cnt[cnt_addr] <= cnt_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         scan_idx_ff   <= '0;
         overlap_ff    <= 1'b0;
         free_found_ff <= 1'b0;
         hit_found_ff  <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan_issue;
         if (cmd.check) begin
            scan_idx_ff   <= '0;
            overlap_ff    <= 1'b0;
            free_found_ff <= 1'b0;
            hit_found_ff  <= 1'b0;
         end else begin
            if (cmd.scan_issue) scan_idx_ff <= scan_idx_ff + SW'(1);
            if (rd_valid_ff) begin
               if (ovl_take) overlap_ff <= 1'b1;
               if (!used_ff[rd_idx_ff] && !free_found_ff) begin
                  free_found_ff <= 1'b1;
                  free_slot_ff  <= rd_idx_ff;
               end
               if (hit_take) begin
                  hit_found_ff  <= 1'b1;
                  hit_idx_ff    <= rd_idx_ff;
                  hit_base_ff   <= rd_base_ff;
                  hit_len_ff    <= rd_len_ff;
                  hit_id_ff     <= rd_id_ff;
                  hit_rights_ff <= rd_rights_ff;
                  hit_cnt_ff    <= rd_cnt_ff;
               end
            end
         end
      end
   end

   assign nid0 = ns_ff ^ seq_ff;
   assign seq1 = seq_ff + 64'd1;
   assign seq2 = seq_ff + 64'd2;
   assign nid1 = ns_ff ^ seq1;

   always_comb begin
      st_out     = ST_OK;
      nid_out    = '0;
      lslot_out  = '0;
      lbase_out  = '0;
      llen_out   = '0;
      flag_out   = 1'b0;
      used_in    = used_ff;
      hidden_in  = hidden_ff;
      closing_in = closing_ff;
      seq_in     = seq_ff;
      row_we     = 1'b0;
      row_addr   = free_slot_ff;
      row_id     = '0;
      cnt_we     = 1'b0;
      cnt_addr   = hit_idx_ff;
      cnt_data   = '0;
      if (early_ff != ST_OK) begin
         st_out = early_ff;
      end else begin
         case (op_ff)
            OP_ADD: begin
               if (overlap_ff) st_out = ST_OVERLAP;
               else if (!free_found_ff) st_out = ST_TABLE_FULL;
               else if (seq_ff == 64'd0 || seq_ff == ALL_ONES) st_out = ST_IDS_GONE;
               else if (nid0 == 64'd0 && seq1 == ALL_ONES) begin
                  st_out = ST_IDS_GONE;
                  seq_in = seq1;
               end else begin
                  nid_out  = (nid0 == 64'd0) ? nid1 : nid0;
                  seq_in   = (nid0 == 64'd0) ? seq2 : seq1;
                  row_we   = 1'b1;
                  row_id   = nid_out;
                  cnt_we   = 1'b1;
                  cnt_addr = free_slot_ff;
                  used_in[free_slot_ff]   = 1'b1;
                  hidden_in[free_slot_ff] = 1'b0;
               end
            end
            OP_REMOVE: begin
               if (!hit_found_ff) begin
                  st_out = ST_NOT_REG;
               end else if (hit_cnt_ff == '0) begin
                  used_in[hit_idx_ff]   = 1'b0;
                  hidden_in[hit_idx_ff] = 1'b0;
               end else begin
                  hidden_in[hit_idx_ff] = 1'b1;
                  flag_out = 1'b1;
               end
            end
            OP_ACQ_LOC, OP_ACQ_REM: begin
               if (!hit_found_ff || req_end > hit_end) st_out = ST_RANGE_REJ;
               else if (op_ff == OP_ACQ_REM && hit_id_ff != exp_id_ff) st_out = ST_STALE_ID;
               else if (op_ff == OP_ACQ_REM && (hit_rights_ff == RIGHTS_LOCAL_RW ||
                        (wr_ff && hit_rights_ff != RIGHTS_GLOBAL_RW)))
                  st_out = ST_PERM_DENIED;
               else if (hit_cnt_ff == LEASE_MAX) st_out = ST_LEASE_LIMIT;
               else begin
                  cnt_we    = 1'b1;
                  cnt_data  = hit_cnt_ff + LEASE_BITS'(1);
                  lslot_out = 4'(hit_idx_ff);
                  lbase_out = hit_base_ff;
                  llen_out  = hit_len_ff;
               end
            end
            OP_RELEASE: begin
               if (rd_cnt_ff == '0) begin
                  st_out = ST_LEASE_LIMIT;
               end else begin
                  cnt_we   = 1'b1;
                  cnt_addr = rel_idx;
                  cnt_data = rd_cnt_ff - LEASE_BITS'(1);
                  if (hidden_ff[rel_idx] && rd_cnt_ff == LEASE_BITS'(1)) begin
                     used_in[rel_idx]   = 1'b0;
                     hidden_in[rel_idx] = 1'b0;
                  end
               end
            end
            OP_CLOSE:  closing_in = 1'b1;
            OP_REOPEN: closing_in = 1'b0;
            OP_TRACKS: flag_out = hit_found_ff;
            default:   st_out = ST_OK;
         endcase
      end
      if (!cmd.exec) begin
         row_we = 1'b0;
         cnt_we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= '0;
         hidden_ff  <= '0;
         closing_ff <= 1'b0;
         seq_ff     <= 64'd1;
         ns_ff      <= '0;
      end else begin
         if (csr_we) ns_ff <= csr_wdata;
         if (cmd.exec) begin
            used_ff    <= used_in;
            hidden_ff  <= hidden_in;
            closing_ff <= closing_in;
            seq_ff     <= seq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_status       <= st_out;
         rsp_new_id       <= nid_out;
         rsp_lease_slot   <= lslot_out;
         rsp_lease_base   <= lbase_out;
         rsp_lease_length <= llen_out;
         rsp_flag         <= flag_out;
      end
   end

endmodule

@@ sv/memory_region_lease_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_region_lease_table
// Table of registered, non-overlapping address ranges with lease counts.
// ----------------------------------------------------------------------------
// One transaction is handled at a time and gives one result transaction.
// Add, remove, acquire and tracks query pass check, scan, scan end and
// execute, walking the slot memory one row per cycle; release passes check,
// one memory read and execute; close and reopen pass check and execute, as
// does any request failing its early checks. The result sits in an output
// register, so a stalled result only holds the table once the next request
// reaches its execute step. No clearing pass is needed after reset.
module memory_region_lease_table #(
   parameter int NUM_SLOTS  = 16,
   parameter int LEASE_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // range_base, range_length, access_rights, expected_id, is_write,
   // release_slot, zero pad
   input  logic [199:0] req_tdata,
   // op
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_id, lease_slot, lease_base, lease_length, flag, zero pad
   output logic [199:0] rsp_tdata,
   // status
   output logic [3:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [63:0]  csr_wdata
);
   import mrlt_pkg::*;

   cmd_type     cmd;
   sts_type     sts;
   logic [3:0]  st, lslot;
   logic [63:0] nid, lbase, llen;
   logic        flag;

   mrlt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mrlt_dp #(
      .NUM_SLOTS  (NUM_SLOTS),
      .LEASE_BITS (LEASE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_op           (req_tuser),
      .req_base         (req_tdata[63:0]),
      .req_length       (req_tdata[127:64]),
      .req_rights       (req_tdata[129:128]),
      .req_expected_id  (req_tdata[193:130]),
      .req_is_write     (req_tdata[194]),
      .req_release_slot (req_tdata[198:195]),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_status       (st),
      .rsp_new_id       (nid),
      .rsp_lease_slot   (lslot),
      .rsp_lease_base   (lbase),
      .rsp_lease_length (llen),
      .rsp_flag         (flag)
   );

   assign rsp_tuser = st;
   assign rsp_tdata = {3'b000, flag, llen, lbase, lslot, nid};

endmodule

@@ sv/mrlt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlt_checker
// Port-level checks of the lease table, bound to the top level.
// ----------------------------------------------------------------------------
module mrlt_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [199:0] rsp_tdata,
   input logic [3:0]   rsp_tuser
);
   import mrlt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while one is in flight");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata[195:0] == '0)
      else $error("failed result carries data");

endmodule

bind memory_region_lease_table mrlt_checker u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
